FILE: src/fpfa_pkg.sv
// fpfa_pkg: shared types and constants of the fixed partition fit allocator
// used by fpfa_seq, the top module and the checker; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package fpfa_pkg;

   localparam int MAX_PARTITIONS = 16;
   localparam int SIZE_BITS      = 16;
   localparam int IDX_BITS       = $clog2(MAX_PARTITIONS);
   localparam int CNT_BITS       = $clog2(MAX_PARTITIONS + 1);
   localparam int SUM_BITS       = 32;
   localparam int PCOUNT_BITS    = 5;
   localparam int CSR_IDX_BITS   = 1;
   localparam int CSR_DATA_BITS  = 5;

   typedef enum logic [1:0] {
      MODE_LOAD    = 2'd0,
      MODE_ALLOC   = 2'd1,
      MODE_RESTART = 2'd2,
      MODE_NONE    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      POL_FIRST = 2'd0,
      POL_BEST  = 2'd1,
      POL_WORST = 2'd2,
      POL_NEXT  = 2'd3
   } policy_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_POLICY = 1'b0,
      CSR_PCOUNT = 1'b1
   } csr_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // outcome of one transaction, handed from the sequencer to the state owner
   typedef struct packed {
      logic                fire;
      mode_type            mode;
      logic                placed;
      logic [IDX_BITS-1:0] idx;
      logic [SIZE_BITS-1:0] size;
      logic [SIZE_BITS-1:0] leftover;
      logic [SIZE_BITS-1:0] req;
   } result_type;

endpackage

`default_nettype wire

FILE: src/fpfa_size_ram.sv
// fpfa_size_ram: single port write, single port read memory with registered read data
// generic; no package needed
`timescale 1ns / 1ps
`default_nettype none

module fpfa_size_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/fpfa_seq.sv
// fpfa_seq: transaction sequencer, partition scan and fit selection
// depends on fpfa_pkg; drives the size memory ports
`timescale 1ns / 1ps
`default_nettype none

module fpfa_seq
   import fpfa_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [1:0]             req_mode,
   input  wire logic [IDX_BITS-1:0]    req_partition_index,
   input  wire logic [SIZE_BITS-1:0]   req_partition_size,
   input  wire logic [SIZE_BITS-1:0]   req_request_size,
   input  wire policy_type             policy,
   input  wire logic [PCOUNT_BITS-1:0] part_count,
   input  wire logic [MAX_PARTITIONS-1:0] occupied,
   input  wire logic [IDX_BITS-1:0]    resume_ptr,
   input  wire logic                   out_free,
   output logic                        ram_wr_en,
   output logic [IDX_BITS-1:0]         ram_wr_addr,
   output logic [SIZE_BITS-1:0]        ram_wr_data,
   output logic                        ram_rd_en,
   output logic [IDX_BITS-1:0]         ram_rd_addr,
   input  wire logic [SIZE_BITS-1:0]   ram_rd_data,
   output result_type                  result
);

   state_type            state_ff, state_in;
   mode_type             mode_ff, mode_in;
   logic [IDX_BITS-1:0]  pidx_ff, pidx_in;
   logic [SIZE_BITS-1:0] psize_ff, psize_in;
   logic [SIZE_BITS-1:0] rsize_ff, rsize_in;
   logic [IDX_BITS-1:0]  addr_ff, addr_in;
   logic [CNT_BITS-1:0]  remain_ff, remain_in;
   logic                 tag_vld_ff, tag_vld_in;
   logic [IDX_BITS-1:0]  tag_idx_ff, tag_idx_in;
   logic                 found_ff, found_in;
   logic [IDX_BITS-1:0]  best_idx_ff, best_idx_in;
   logic [SIZE_BITS-1:0] best_size_ff, best_size_in;

   logic [CNT_BITS-1:0]  n_use;
   logic [IDX_BITS-1:0]  start_addr;
   logic                 cand_free, cand_fits, take;
   logic                 placed;

   always_comb begin
      if (32'(part_count) > MAX_PARTITIONS) begin
         n_use = CNT_BITS'(MAX_PARTITIONS);
      end else begin
         n_use = CNT_BITS'(part_count);
      end
   end

   // a stale next fit pointer restarts the search at partition zero
   always_comb begin
      if (policy == POL_NEXT && CNT_BITS'(resume_ptr) < n_use) begin
         start_addr = resume_ptr;
      end else begin
         start_addr = '0;
      end
   end

   assign cand_free = !occupied[tag_idx_ff];
   assign cand_fits = rsize_ff <= ram_rd_data;

   always_comb begin
      take = 1'b0;
      case (policy)
         POL_FIRST, POL_NEXT: take = !found_ff && cand_free && cand_fits;
         POL_BEST: take = cand_free && cand_fits && (!found_ff || ram_rd_data < best_size_ff);
         POL_WORST: take = cand_free && (!found_ff || ram_rd_data > best_size_ff);
         default: take = 1'b0;
      endcase
   end

   // worst fit picks the largest free partition first and only then checks the fit
   assign placed = found_ff && (rsize_ff <= best_size_ff);

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      pidx_in      = pidx_ff;
      psize_in     = psize_ff;
      rsize_in     = rsize_ff;
      addr_in      = addr_ff;
      remain_in    = remain_ff;
      tag_vld_in   = 1'b0;
      tag_idx_in   = tag_idx_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_size_in = best_size_ff;
      req_stall    = 1'b1;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = addr_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = pidx_ff;
      ram_wr_data  = psize_ff;
      result       = '0;

      if (tag_vld_ff && take) begin
         found_in     = 1'b1;
         best_idx_in  = tag_idx_ff;
         best_size_in = ram_rd_data;
      end

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               mode_in   = mode_type'(req_mode);
               pidx_in   = req_partition_index;
               psize_in  = req_partition_size;
               rsize_in  = req_request_size;
               addr_in   = start_addr;
               remain_in = n_use;
               found_in  = 1'b0;
               if (mode_type'(req_mode) == MODE_ALLOC && n_use != '0) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            ram_rd_en  = 1'b1;
            tag_vld_in = 1'b1;
            tag_idx_in = addr_ff;
            remain_in  = remain_ff - CNT_BITS'(1);
            if (CNT_BITS'(addr_ff) == n_use - CNT_BITS'(1)) begin
               addr_in = '0;
            end else begin
               addr_in = addr_ff + IDX_BITS'(1);
            end
            if (remain_ff == CNT_BITS'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in         = ST_IDLE;
               result.fire      = 1'b1;
               result.mode      = mode_ff;
               result.req       = rsize_ff;
               ram_wr_en        = (mode_ff == MODE_LOAD) && (32'(pidx_ff) < MAX_PARTITIONS);
               if (mode_ff == MODE_ALLOC && placed) begin
                  result.placed   = 1'b1;
                  result.idx      = best_idx_ff;
                  result.size     = best_size_ff;
                  result.leftover = best_size_ff - rsize_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         tag_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         tag_vld_ff <= tag_vld_in;
         found_ff   <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      pidx_ff      <= pidx_in;
      psize_ff     <= psize_in;
      rsize_ff     <= rsize_in;
      addr_ff      <= addr_in;
      remain_ff    <= remain_in;
      tag_idx_ff   <= tag_idx_in;
      best_idx_ff  <= best_idx_in;
      best_size_ff <= best_size_in;
   end

endmodule

`default_nettype wire

FILE: src/fixed_partition_fit_allocator.sv
// Usage of the fixed partition fit allocator.
// Input channel req_*: one transaction per item, mode 0 loads a partition
// size, mode 1 allocates request_size, mode 2 restarts the run (clears
// occupied marks, next fit pointer and both fragmentation totals).
// Result channel rsp_*: exactly one transaction per input item, in order.
// Configuration channel csr_*: index 0 policy, index 1 partition count;
// always ready, write only while no item is in flight.
// Sequence: load, restart and unused mode go from acceptance straight to the
// done state and the result register; an allocate reads the size memory
// one partition a cycle through its single read port for all partitions in
// use, then drains for the last compare after the read latency, then hands
// its result over in the done state. The sequencer passes through idle
// before the next acceptance.
// One item is processed at a time; the next is taken as soon as the
// previous result sits in the output register, even if that is stalled.
// rsp_stall holds the result register and, once the next item is finished,
// holds the sequencer until the register frees.
// Reset clears all control state, marks, pointer, totals and configuration
// to policy first fit and 16 partitions; sizes are undefined until loaded.
// depends on fpfa_pkg, fpfa_seq, fpfa_size_ram
`timescale 1ns / 1ps
`default_nettype none

module fixed_partition_fit_allocator
   import fpfa_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [1:0]               req_mode,
   input  wire logic [IDX_BITS-1:0]      req_partition_index,
   input  wire logic [SIZE_BITS-1:0]     req_partition_size,
   input  wire logic [SIZE_BITS-1:0]     req_request_size,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_placed,
   output logic [IDX_BITS-1:0]           rsp_chosen_index,
   output logic [SIZE_BITS-1:0]          rsp_chosen_size,
   output logic [SIZE_BITS-1:0]          rsp_leftover,
   output logic [SUM_BITS-1:0]           rsp_internal_total,
   output logic [SUM_BITS-1:0]           rsp_external_total,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_data
);

   policy_type                 policy_ff;
   logic [PCOUNT_BITS-1:0]     pcount_ff;
   logic [MAX_PARTITIONS-1:0]  occ_ff, occ_in;
   logic [IDX_BITS-1:0]        ptr_ff, ptr_in;
   logic [SUM_BITS-1:0]        int_sum_ff, int_sum_in;
   logic [SUM_BITS-1:0]        ext_sum_ff, ext_sum_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_placed_ff;
   logic [IDX_BITS-1:0]        rsp_idx_ff;
   logic [SIZE_BITS-1:0]       rsp_size_ff;
   logic [SIZE_BITS-1:0]       rsp_left_ff;
   logic [SUM_BITS-1:0]        rsp_int_ff;
   logic [SUM_BITS-1:0]        rsp_ext_ff;

   logic                       out_free;
   result_type                 result;
   logic                       ram_wr_en, ram_rd_en;
   logic [IDX_BITS-1:0]        ram_wr_addr, ram_rd_addr;
   logic [SIZE_BITS-1:0]       ram_wr_data, ram_rd_data;
   logic [SUM_BITS:0]          int_add, ext_add;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POL_FIRST;
         pcount_ff <= PCOUNT_BITS'(MAX_PARTITIONS);
      end else if (csr_valid) begin
         case (csr_reg_type'(csr_index))
            CSR_POLICY: policy_ff <= policy_type'(csr_data[1:0]);
            CSR_PCOUNT: pcount_ff <= PCOUNT_BITS'(csr_data);
            default: ;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   fpfa_size_ram #(
      .DEPTH (MAX_PARTITIONS),
      .WIDTH (SIZE_BITS)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   fpfa_seq u_seq (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_partition_index (req_partition_index),
      .req_partition_size  (req_partition_size),
      .req_request_size    (req_request_size),
      .policy              (policy_ff),
      .part_count          (pcount_ff),
      .occupied            (occ_ff),
      .resume_ptr          (ptr_ff),
      .out_free            (out_free),
      .ram_wr_en           (ram_wr_en),
      .ram_wr_addr         (ram_wr_addr),
      .ram_wr_data         (ram_wr_data),
      .ram_rd_en           (ram_rd_en),
      .ram_rd_addr         (ram_rd_addr),
      .ram_rd_data         (ram_rd_data),
      .result              (result)
   );

   // saturating totals
   assign int_add = {1'b0, int_sum_ff} + (SUM_BITS+1)'(result.leftover);
   assign ext_add = {1'b0, ext_sum_ff} + (SUM_BITS+1)'(result.req);

   always_comb begin
      occ_in     = occ_ff;
      ptr_in     = ptr_ff;
      int_sum_in = int_sum_ff;
      ext_sum_in = ext_sum_ff;
      if (result.fire) begin
         case (result.mode)
            MODE_RESTART: begin
               occ_in     = '0;
               ptr_in     = '0;
               int_sum_in = '0;
               ext_sum_in = '0;
            end
            MODE_ALLOC: begin
               if (result.placed) begin
                  occ_in[result.idx] = 1'b1;
                  ptr_in             = result.idx;
                  int_sum_in = int_add[SUM_BITS] ? '1 : int_add[SUM_BITS-1:0];
               end else begin
                  ext_sum_in = ext_add[SUM_BITS] ? '1 : ext_add[SUM_BITS-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (result.fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         ptr_ff       <= '0;
         int_sum_ff   <= '0;
         ext_sum_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         ptr_ff       <= ptr_in;
         int_sum_ff   <= int_sum_in;
         ext_sum_ff   <= ext_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.fire) begin
         rsp_placed_ff <= result.placed;
         rsp_idx_ff    <= result.idx;
         rsp_size_ff   <= result.size;
         rsp_left_ff   <= result.leftover;
         rsp_int_ff    <= int_sum_in;
         rsp_ext_ff    <= ext_sum_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_placed         = rsp_placed_ff;
   assign rsp_chosen_index   = rsp_idx_ff;
   assign rsp_chosen_size    = rsp_size_ff;
   assign rsp_leftover       = rsp_left_ff;
   assign rsp_internal_total = rsp_int_ff;
   assign rsp_external_total = rsp_ext_ff;

endmodule

`default_nettype wire

FILE: src/fpfa_checker.sv
// fpfa_checker: port level assertions for the fixed partition fit allocator
// depends on fpfa_pkg; bound to fixed_partition_fit_allocator below
`timescale 1ns / 1ps
`default_nettype none

module fpfa_checker
   import fpfa_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic [1:0]               req_mode,
   input wire logic [IDX_BITS-1:0]      req_partition_index,
   input wire logic [SIZE_BITS-1:0]     req_partition_size,
   input wire logic [SIZE_BITS-1:0]     req_request_size,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic                     rsp_placed,
   input wire logic [IDX_BITS-1:0]      rsp_chosen_index,
   input wire logic [SIZE_BITS-1:0]     rsp_chosen_size,
   input wire logic [SIZE_BITS-1:0]     rsp_leftover,
   input wire logic [SUM_BITS-1:0]      rsp_internal_total,
   input wire logic [SUM_BITS-1:0]      rsp_external_total
);

   // a stalled request transaction keeps its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_mode)
         && $stable(req_partition_index) && $stable(req_partition_size)
         && $stable(req_request_size))
      else $error("request changed while stalled");

   // a stalled result transaction keeps valid, placed, index and both totals
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_placed)
         && $stable(rsp_chosen_index) && $stable(rsp_internal_total)
         && $stable(rsp_external_total))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   // an unplaced transaction reports no partition and no waste
   a_unplaced_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_placed |-> rsp_chosen_index == '0
         && rsp_chosen_size == '0 && rsp_leftover == '0)
      else $error("unplaced result carries a partition");

   a_leftover_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_placed |-> rsp_leftover <= rsp_chosen_size)
      else $error("leftover exceeds partition size");

endmodule

bind fixed_partition_fit_allocator fpfa_checker u_fpfa_checker (.*);

`default_nettype wire
